FILE: rtl/est_pkg.sv
// Shared types, constants and series tables for the scaled Euler matrix block.
package est_pkg;

  // Angle format
  localparam int ANGLE_BITS = 16;
  localparam int QBITS      = ANGLE_BITS - 2;
  localparam int XPROD_W    = QBITS + 31;

  // Series arithmetic, Q30
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
  localparam int          TERMS       = 7;
  localparam int          RECIP_W     = 40;
  localparam int          RECIP_SH    = 40;
  localparam logic [63:0] RECIP_ONE   = 64'h100_0000_0000;

  // ceil(2^40 / d) gives the exact quotient for any 32-bit dividend
  localparam logic [RECIP_W-1:0] SIN_RECIP [TERMS] = '{
    40'((RECIP_ONE + 64'd5)   / 64'd6),
    40'((RECIP_ONE + 64'd19)  / 64'd20),
    40'((RECIP_ONE + 64'd41)  / 64'd42),
    40'((RECIP_ONE + 64'd71)  / 64'd72),
    40'((RECIP_ONE + 64'd109) / 64'd110),
    40'((RECIP_ONE + 64'd155) / 64'd156),
    40'((RECIP_ONE + 64'd209) / 64'd210)
  };
  localparam logic [RECIP_W-1:0] COS_RECIP [TERMS] = '{
    40'((RECIP_ONE + 64'd1)   / 64'd2),
    40'((RECIP_ONE + 64'd11)  / 64'd12),
    40'((RECIP_ONE + 64'd29)  / 64'd30),
    40'((RECIP_ONE + 64'd55)  / 64'd56),
    40'((RECIP_ONE + 64'd89)  / 64'd90),
    40'((RECIP_ONE + 64'd131) / 64'd132),
    40'((RECIP_ONE + 64'd181) / 64'd182)
  };
  // Odd terms are subtracted
  localparam logic [TERMS-1:0] TERM_ODD = 7'b1010101;

  // Reciprocal scale divider, two quotient bits per register stage
  localparam int DIV_BITS = 28;
  localparam int REM_W    = 18;
  localparam int DEN_W    = 17;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_z;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
    logic signed [31:0] move_x;
    logic signed [31:0] move_y;
    logic signed [31:0] move_z;
  } est_in_t;

  typedef struct packed {
    logic signed [31:0] m00;
    logic signed [31:0] m01;
    logic signed [31:0] m02;
    logic signed [31:0] m10;
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m20;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] t0;
    logic signed [31:0] t1;
    logic signed [31:0] t2;
  } est_out_t;

  // Fields that ride along unchanged through the series cells
  typedef struct packed {
    logic             mode;
    logic [2:0][15:0] scale;
    logic [2:0][31:0] move;
  } est_side_t;

  // One angle's series state
  typedef struct packed {
    logic [1:0]         quad;
    logic [31:0]        x2;
    logic [31:0]        ts;
    logic [31:0]        tc;
    logic signed [33:0] ss;
    logic signed [33:0] cs;
  } est_ang_t;

  // One scale's divider state: quotient shifts in at the bottom of num
  typedef struct packed {
    logic [DIV_BITS-1:0] num;
    logic [REM_W-1:0]    rem;
    logic [DEN_W-1:0]    den;
  } est_div_t;

  typedef struct packed {
    est_side_t          side;
    est_ang_t [2:0]     ang;
    est_div_t [2:0]     dv;
  } est_pipe_t;

endpackage

FILE: rtl/euler_scale_transform_matrix.sv
// Top level: scaled Y-X-Z Euler rotation matrix with translation, streaming.
//
// Input beat: mode, three binary angles, three Q8.8 scales, three Q16.16
// translations. Output beat: nine Q16.16 matrix entries (column major) and
// the translation, which reads zero in normal-matrix mode.
// Both channels use valid/ready. One beat in gives exactly one beat out,
// in order.
// Throughput: one beat per cycle while the receiver is ready. The pipeline has
// 2 front stages, 7 series cells of 2 stages and 5 back stages.
// The row of series cells evaluates one Taylor term per cell for all three
// angles and, alongside, retires four bits of the reciprocal-scale division.
// Every stage holds its beat when the stage after it is full and held, so a stalled
// receiver fills the empty stages first; input ready drops only once the
// pipeline is full up to the front.
// Reset empties the pipeline; beats in flight are dropped and none are produced by it.
module euler_scale_transform_matrix import est_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  est_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output est_out_t out_data_o
);

  est_pipe_t          pipe  [TERMS+1];
  logic [TERMS:0]     pvalid;
  logic [TERMS:0]     pready;

  // Angle reduction and seeds
  est_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (pvalid[0]),
    .ready_i (pready[0]),
    .data_o  (pipe[0])
  );

  // Row of series cells
  for (genvar g = 0; g < TERMS; g++) begin : g_cell
    est_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .odd_i       (TERM_ODD[g]),
      .sin_recip_i (SIN_RECIP[g]),
      .cos_recip_i (COS_RECIP[g]),
      .valid_i     (pvalid[g]),
      .ready_o     (pready[g]),
      .data_i      (pipe[g]),
      .valid_o     (pvalid[g+1]),
      .ready_i     (pready[g+1]),
      .data_o      (pipe[g+1])
    );
  end

  // Matrix assembly and output register
  est_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pvalid[TERMS]),
    .ready_o (pready[TERMS]),
    .data_i  (pipe[TERMS]),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule

FILE: rtl/est_front.sv
// Front end: angle reduction, series argument and its square, divider set-up.
module est_front import est_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  est_in_t   data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output est_pipe_t data_o
);

  typedef struct packed {
    est_side_t        side;
    logic [2:0][1:0]  quad;
    logic [2:0][30:0] x;
  } est_arg_t;

  localparam logic [61:0] X2_RND = 62'd1 << 29;
  localparam logic [XPROD_W-1:0] X_RND = XPROD_W'(1) << (QBITS - 1);

  logic [1:0] v_q;
  logic       rdy0, rdy1;
  est_arg_t   s0_d, s0_q;
  est_pipe_t  s1_d, s1_q;

  assign rdy1    = !v_q[1] || ready_i;
  assign rdy0    = !v_q[0] || rdy1;
  assign ready_o = rdy0;
  assign valid_o = v_q[1];
  assign data_o  = s1_q;

  // Stage 0: quadrant and Q30 argument for each angle
  always_comb begin
    logic [2:0][15:0]    rot;
    logic [ANGLE_BITS-1:0] a;
    logic [XPROD_W-1:0]  prod;
    rot = {data_i.rot_z, data_i.rot_y, data_i.rot_x};
    s0_d.side.mode  = data_i.mode;
    s0_d.side.scale = {data_i.scale_z, data_i.scale_y, data_i.scale_x};
    s0_d.side.move  = {data_i.move_z, data_i.move_y, data_i.move_x};
    for (int i = 0; i < 3; i++) begin
      a = ANGLE_BITS'($signed(rot[i]));
      // model matrix: half turn on x
      if (i == 0 && !data_i.mode) begin
        a[ANGLE_BITS-1] = ~a[ANGLE_BITS-1];
      end
      s0_d.quad[i] = a[ANGLE_BITS-1 -: 2];
      prod = XPROD_W'(a[QBITS-1:0]) * XPROD_W'(HALF_PI_Q30) + X_RND;
      s0_d.x[i] = 31'(prod >> QBITS);
    end
  end

  // Stage 1: square of the argument, series seeds, divider seeds
  always_comb begin
    logic [15:0] m;
    s1_d.side = s0_q.side;
    for (int i = 0; i < 3; i++) begin
      s1_d.ang[i].quad = s0_q.quad[i];
      s1_d.ang[i].x2   = 32'((62'(s0_q.x[i]) * 62'(s0_q.x[i]) + X2_RND) >> 30);
      s1_d.ang[i].ts   = 32'(s0_q.x[i]);
      s1_d.ang[i].tc   = ONE_Q30;
      s1_d.ang[i].ss   = 34'(s0_q.x[i]);
      s1_d.ang[i].cs   = 34'(ONE_Q30);
      m = s0_q.side.scale[i][15] ? 16'(-s0_q.side.scale[i]) : s0_q.side.scale[i];
      s1_d.dv[i].num = DIV_BITS'(26'h200_0000 + 26'(m));
      s1_d.dv[i].rem = '0;
      s1_d.dv[i].den = {m, 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy0) v_q[0] <= valid_i;
      if (rdy1) v_q[1] <= v_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && valid_i) s0_q <= s0_d;
    if (rdy1 && v_q[0])  s1_q <= s1_d;
  end

endmodule

FILE: rtl/est_cell.sv
// One series term cell: multiply by x^2, divide by the term constant, accumulate.
module est_cell import est_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               odd_i,
  input  logic [RECIP_W-1:0] sin_recip_i,
  input  logic [RECIP_W-1:0] cos_recip_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  est_pipe_t          data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output est_pipe_t          data_o
);

  logic      a_valid_q, b_valid_q;
  logic      a_rdy, b_rdy;
  est_pipe_t a_d, a_q, b_d, b_q;

  // One restoring division step
  function automatic est_div_t div_step(est_div_t d);
    est_div_t         r;
    logic [REM_W-1:0] rem;
    r     = d;
    rem   = {d.rem[REM_W-2:0], d.num[DIV_BITS-1]};
    r.num = {d.num[DIV_BITS-2:0], 1'b0};
    if (rem >= REM_W'(d.den)) begin
      rem      = rem - REM_W'(d.den);
      r.num[0] = 1'b1;
    end
    r.rem = rem;
    return r;
  endfunction

  assign b_rdy   = !b_valid_q || ready_i;
  assign a_rdy   = !a_valid_q || b_rdy;
  assign ready_o = a_rdy;
  assign valid_o = b_valid_q;
  assign data_o  = b_q;

  // Stage A: previous term times x^2, and two divider steps
  always_comb begin
    a_d = data_i;
    for (int i = 0; i < 3; i++) begin
      a_d.ang[i].ts = 32'((64'(data_i.ang[i].ts) * 64'(data_i.ang[i].x2)) >> 30);
      a_d.ang[i].tc = 32'((64'(data_i.ang[i].tc) * 64'(data_i.ang[i].x2)) >> 30);
      a_d.dv[i]     = div_step(div_step(data_i.dv[i]));
    end
  end

  // Stage B: exact divide by reciprocal, then add or subtract the term; two divider steps
  always_comb begin
    logic [31:0] tsn, tcn;
    b_d = a_q;
    for (int i = 0; i < 3; i++) begin
      tsn = 32'((72'(a_q.ang[i].ts) * 72'(sin_recip_i)) >> RECIP_SH);
      tcn = 32'((72'(a_q.ang[i].tc) * 72'(cos_recip_i)) >> RECIP_SH);
      b_d.ang[i].ts = tsn;
      b_d.ang[i].tc = tcn;
      if (odd_i) begin
        b_d.ang[i].ss = a_q.ang[i].ss - $signed({2'b00, tsn});
        b_d.ang[i].cs = a_q.ang[i].cs - $signed({2'b00, tcn});
      end else begin
        b_d.ang[i].ss = a_q.ang[i].ss + $signed({2'b00, tsn});
        b_d.ang[i].cs = a_q.ang[i].cs + $signed({2'b00, tcn});
      end
      b_d.dv[i] = div_step(div_step(a_q.dv[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (a_rdy) a_valid_q <= valid_i;
      if (b_rdy) b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && valid_i)   a_q <= a_d;
    if (b_rdy && a_valid_q) b_q <= b_d;
  end

endmodule

FILE: rtl/est_back.sv
// Back end: sine/cosine finish, scale factor, matrix brackets, entries, output register.
module est_back import est_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  est_pipe_t data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output est_out_t  data_o
);

  typedef struct packed {
    logic             mode;
    logic [2:0][31:0] move;
    logic [2:0][17:0] s;
    logic [2:0][17:0] c;
    logic [2:0][31:0] f;
  } est_trig_t;

  typedef struct packed {
    logic             mode;
    logic [2:0][31:0] move;
    logic [9:0][35:0] p;
    logic [17:0]      s2;
    logic [17:0]      s3;
    logic [17:0]      c3;
    logic [2:0][31:0] f;
  } est_pair_t;

  typedef struct packed {
    logic             mode;
    logic [2:0][31:0] move;
    logic [8:0][27:0] b;
    logic [2:0][31:0] f;
  } est_brk_t;

  typedef struct packed {
    logic             mode;
    logic [2:0][31:0] move;
    logic [8:0][59:0] e;
  } est_ent_t;

  localparam logic signed [51:0] B_RND   = 52'sd8388608;
  localparam logic signed [59:0] E_RND   = 60'sd8388608;
  localparam logic signed [35:0] SAT_MAX = 36'sd2147483647;
  localparam logic signed [35:0] SAT_MIN = -36'sd2147483648;

  logic [4:0] v_q;
  logic [5:0] rdy;
  est_trig_t  r1_d, r1_q;
  est_pair_t  r2_d, r2_q;
  est_brk_t   r3_d, r3_q;
  est_ent_t   r4_d, r4_q;
  est_out_t   r5_d, r5_q;

  // Stage handshake: a stage takes a beat when empty or draining
  always_comb begin
    rdy[5] = ready_i;
    for (int i = 4; i >= 0; i--) begin
      rdy[i] = !v_q[i] || rdy[i+1];
    end
  end
  assign ready_o = rdy[0];
  assign valid_o = v_q[4];
  assign data_o  = r5_q;

  // R1: clamp, round to Q16, quadrant fold; scale factor
  always_comb begin
    logic signed [33:0] ssc, csc;
    logic signed [17:0] sr, cr;
    logic [31:0]        q;
    r1_d.mode = data_i.side.mode;
    r1_d.move = data_i.side.move;
    for (int i = 0; i < 3; i++) begin
      ssc = data_i.ang[i].ss[33] ? '0 : data_i.ang[i].ss;
      csc = data_i.ang[i].cs[33] ? '0 : data_i.ang[i].cs;
      sr  = 18'((ssc + 34'sd8192) >>> 14);
      cr  = 18'((csc + 34'sd8192) >>> 14);
      unique case (data_i.ang[i].quad)
        2'd0: begin r1_d.s[i] = sr;  r1_d.c[i] = cr;  end
        2'd1: begin r1_d.s[i] = cr;  r1_d.c[i] = -sr; end
        2'd2: begin r1_d.s[i] = -sr; r1_d.c[i] = -cr; end
        default: begin r1_d.s[i] = -cr; r1_d.c[i] = sr; end
      endcase
      q = {7'b0, data_i.dv[i].num[24:0]};
      if (!data_i.side.mode) begin
        r1_d.f[i] = {{8{data_i.side.scale[i][15]}}, data_i.side.scale[i], 8'h00};
      end else if (data_i.side.scale[i] == '0) begin
        r1_d.f[i] = 32'h7FFF_FFFF;
      end else begin
        r1_d.f[i] = data_i.side.scale[i][15] ? -q : q;
      end
    end
  end

  // R2: pairwise products; angle y gives 1, x gives 2, z gives 3
  always_comb begin
    logic signed [35:0] s1, c1, s2, c2, s3, c3;
    s1 = 36'($signed(r1_q.s[1])); c1 = 36'($signed(r1_q.c[1]));
    s2 = 36'($signed(r1_q.s[0])); c2 = 36'($signed(r1_q.c[0]));
    s3 = 36'($signed(r1_q.s[2])); c3 = 36'($signed(r1_q.c[2]));
    r2_d.mode = r1_q.mode;
    r2_d.move = r1_q.move;
    r2_d.f    = r1_q.f;
    r2_d.s2   = r1_q.s[0];
    r2_d.s3   = r1_q.s[2];
    r2_d.c3   = r1_q.c[2];
    r2_d.p[0] = s1 * s2;
    r2_d.p[1] = c1 * s2;
    r2_d.p[2] = c1 * c3;
    r2_d.p[3] = c2 * s3;
    r2_d.p[4] = c3 * s1;
    r2_d.p[5] = c1 * s3;
    r2_d.p[6] = c2 * c3;
    r2_d.p[7] = s1 * s3;
    r2_d.p[8] = c2 * s1;
    r2_d.p[9] = c1 * c2;
  end

  // R3: brackets in Q48, rounded to Q24
  always_comb begin
    logic signed [51:0] b [9];
    logic signed [51:0] ps12, pc1s2, s3, c3;
    ps12  = 52'($signed(r2_q.p[0]));
    pc1s2 = 52'($signed(r2_q.p[1]));
    s3    = 52'($signed(r2_q.s3));
    c3    = 52'($signed(r2_q.c3));
    b[0] = (52'($signed(r2_q.p[2])) <<< 16) + ps12 * s3;
    b[1] = 52'($signed(r2_q.p[3])) <<< 16;
    b[2] = pc1s2 * s3 - (52'($signed(r2_q.p[4])) <<< 16);
    b[3] = ps12 * c3 - (52'($signed(r2_q.p[5])) <<< 16);
    b[4] = 52'($signed(r2_q.p[6])) <<< 16;
    b[5] = pc1s2 * c3 + (52'($signed(r2_q.p[7])) <<< 16);
    b[6] = 52'($signed(r2_q.p[8])) <<< 16;
    b[7] = -(52'($signed(r2_q.s2)) <<< 32);
    b[8] = 52'($signed(r2_q.p[9])) <<< 16;
    r3_d.mode = r2_q.mode;
    r3_d.move = r2_q.move;
    r3_d.f    = r2_q.f;
    for (int i = 0; i < 9; i++) begin
      r3_d.b[i] = 28'((b[i] + B_RND) >>> 24);
    end
  end

  // R4: bracket times column factor
  always_comb begin
    r4_d.mode = r3_q.mode;
    r4_d.move = r3_q.move;
    for (int col = 0; col < 3; col++) begin
      for (int row = 0; row < 3; row++) begin
        r4_d.e[3*col+row] = 60'($signed(r3_q.b[3*col+row])) * 60'($signed(r3_q.f[col]));
      end
    end
  end

  // R5: round to Q16 and saturate
  always_comb begin
    logic signed [35:0] v;
    logic [8:0][31:0]   m;
    for (int i = 0; i < 9; i++) begin
      v = 36'(($signed(r4_q.e[i]) + E_RND) >>> 24);
      if (v > SAT_MAX) begin
        m[i] = 32'h7FFF_FFFF;
      end else if (v < SAT_MIN) begin
        m[i] = 32'h8000_0000;
      end else begin
        m[i] = 32'(v);
      end
    end
    r5_d.m00 = m[0]; r5_d.m01 = m[1]; r5_d.m02 = m[2];
    r5_d.m10 = m[3]; r5_d.m11 = m[4]; r5_d.m12 = m[5];
    r5_d.m20 = m[6]; r5_d.m21 = m[7]; r5_d.m22 = m[8];
    r5_d.t0  = r4_q.mode ? '0 : r4_q.move[0];
    r5_d.t1  = r4_q.mode ? '0 : r4_q.move[1];
    r5_d.t2  = r4_q.mode ? '0 : r4_q.move[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= valid_i;
      for (int i = 1; i < 5; i++) begin
        if (rdy[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && valid_i) r1_q <= r1_d;
    if (rdy[1] && v_q[0])  r2_q <= r2_d;
    if (rdy[2] && v_q[1])  r3_q <= r3_d;
    if (rdy[3] && v_q[2])  r4_q <= r4_d;
    if (rdy[4] && v_q[3])  r5_q <= r5_d;
  end

endmodule
